// ----- design/sirc_pkg.sv -----
package sirc_pkg;

  // alphabet storage held by the configuration registers
  localparam int REG_SYMBOLS    = 16;
  localparam int MAX_SYMBOLS    = 16;
  localparam int SYMBOL_BITS    = 8;
  localparam int DIGIT_BITS     = 4;
  localparam int COUNT_BITS     = 5;
  localparam int ALPHA_BITS     = 64;
  localparam int CFG_INDEX_BITS = 2;

  // quotient bits retired per divider cycle
  localparam int DIV_STEP = 8;

  // character codes
  localparam logic [SYMBOL_BITS-1:0] MINUS_CHAR = 8'h2D;
  localparam logic [SYMBOL_BITS-1:0] PLUS_CHAR  = 8'h2B;
  localparam logic [SYMBOL_BITS-1:0] SPACE_CHAR = 8'd32;
  localparam logic [SYMBOL_BITS-1:0] DEL_CHAR   = 8'd127;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SYMBOL_COUNT  = 2'd0,
    REG_ALPHABET_LOW  = 2'd1,
    REG_ALPHABET_HIGH = 2'd2
  } cfg_reg_t;

  typedef logic [REG_SYMBOLS-1:0][SYMBOL_BITS-1:0] sym_array_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic push_sign;
    logic rd;
    logic push_digit;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic alph_valid;
    logic neg;
    logic digit_final;
    logic ptr_zero;
    logic out_free;
  } dp_status_t;

endpackage

// ----- design/sirc_cfg_if.sv -----
interface sirc_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [sirc_pkg::CFG_INDEX_BITS-1:0]  index;
  logic [sirc_pkg::ALPHA_BITS-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/sirc_value_if.sv -----
interface sirc_value_if #(
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// ----- design/sirc_char_if.sv -----
interface sirc_char_if;
  logic                              valid;
  logic                              ready;
  logic [sirc_pkg::SYMBOL_BITS-1:0]  character;
  logic                              last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

// ----- design/sirc_cfg.sv -----
module sirc_cfg (
  input  logic                              clk,
  input  logic                              rst,
  sirc_cfg_if.sink                          cfg,
  output logic [sirc_pkg::COUNT_BITS-1:0]   radix,
  output sirc_pkg::sym_array_t              symbols,
  output logic                              alph_valid
);

  logic [sirc_pkg::COUNT_BITS-1:0] symbol_count;
  logic [sirc_pkg::ALPHA_BITS-1:0] alphabet_low;
  logic [sirc_pkg::ALPHA_BITS-1:0] alphabet_high;
  logic                            valid_comb;

  assign cfg.ready = 1'b1;

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count  <= '0;
      alphabet_low  <= '0;
      alphabet_high <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        sirc_pkg::REG_SYMBOL_COUNT:  symbol_count  <= cfg.data[sirc_pkg::COUNT_BITS-1:0];
        sirc_pkg::REG_ALPHABET_LOW:  alphabet_low  <= cfg.data;
        sirc_pkg::REG_ALPHABET_HIGH: alphabet_high <= cfg.data;
        default: ;
      endcase
    end
  end

  assign radix   = symbol_count;
  assign symbols = {alphabet_high, alphabet_low};

  // alphabet check: count range, printable non-sign symbols, no repeats
  always_comb begin
    valid_comb = (symbol_count >= sirc_pkg::COUNT_BITS'(2))
              && (symbol_count <= sirc_pkg::COUNT_BITS'(sirc_pkg::MAX_SYMBOLS))
              && (symbol_count <= sirc_pkg::COUNT_BITS'(sirc_pkg::REG_SYMBOLS));
    for (int i = 0; i < sirc_pkg::REG_SYMBOLS; i++) begin
      if (sirc_pkg::COUNT_BITS'(i) < symbol_count) begin
        if (symbols[i] <= sirc_pkg::SPACE_CHAR || symbols[i] >= sirc_pkg::DEL_CHAR
            || symbols[i] == sirc_pkg::PLUS_CHAR || symbols[i] == sirc_pkg::MINUS_CHAR) begin
          valid_comb = 1'b0;
        end
        for (int j = i + 1; j < sirc_pkg::REG_SYMBOLS; j++) begin
          if (sirc_pkg::COUNT_BITS'(j) < symbol_count && symbols[i] == symbols[j]) begin
            valid_comb = 1'b0;
          end
        end
      end
    end
  end

  // registered check, sampled by the controller after an item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      alph_valid <= 1'b0;
    end else begin
      alph_valid <= valid_comb;
    end
  end

endmodule

// ----- design/sirc_ctrl.sv -----
module sirc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sirc_pkg::dp_status_t status,
  output sirc_pkg::dp_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_START = 6'b000010,
    S_DIV   = 6'b000100,
    S_SIGN  = 6'b001000,
    S_READ  = 6'b010000,
    S_SHOW  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        state_next = status.alph_valid ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.digit_final) begin
          state_next = status.neg ? S_SIGN : S_READ;
        end
      end
      S_SIGN: begin
        if (status.out_free) begin
          cmd.push_sign = 1'b1;
          state_next    = S_READ;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_SHOW;
      end
      S_SHOW: begin
        if (status.out_free) begin
          cmd.push_digit = 1'b1;
          state_next     = status.ptr_zero ? S_IDLE : S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- design/sirc_dp.sv -----
module sirc_dp #(
  parameter int VALUE_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic signed [VALUE_BITS-1:0]     value,
  input  logic [sirc_pkg::COUNT_BITS-1:0]  radix,
  input  sirc_pkg::sym_array_t             symbols,
  input  logic                             alph_valid,
  input  sirc_pkg::dp_cmd_t                cmd,
  output sirc_pkg::dp_status_t             status,
  sirc_char_if.source                      chars
);

  localparam int DIV_STEPS = (VALUE_BITS + sirc_pkg::DIV_STEP - 1) / sirc_pkg::DIV_STEP;
  localparam int DIV_BITS  = DIV_STEPS * sirc_pkg::DIV_STEP;
  localparam int STEP_W    = $clog2(DIV_STEPS) + 1;
  localparam int IDX_W     = $clog2(VALUE_BITS);
  localparam int DW        = sirc_pkg::DIGIT_BITS;

  logic [DIV_BITS-1:0]  quo;
  logic [DIV_BITS-1:0]  quo_w;
  logic [DW-1:0]        rem;
  logic [DW-1:0]        rem_w;
  logic [DW:0]          trial;
  logic                 ge;
  logic [STEP_W-1:0]    step_cnt;
  logic [IDX_W-1:0]     wr_idx;
  logic [IDX_W-1:0]     rd_ptr;
  logic                 neg;
  logic [VALUE_BITS-1:0] mag;
  logic                 step_last;
  logic                 full;
  logic                 digit_final;
  logic [DW-1:0]        mem [VALUE_BITS];
  logic [DW-1:0]        rd_data;
  logic                 out_valid;
  logic [sirc_pkg::SYMBOL_BITS-1:0] character;
  logic                 last;

  // magnitude of the incoming number; the most negative value wraps to itself
  assign mag = value[VALUE_BITS-1] ? (~value + 1'b1) : value;

  // restoring division, DIV_STEP quotient bits per cycle
  always_comb begin
    rem_w = rem;
    quo_w = quo;
    trial = '0;
    ge    = 1'b0;
    for (int k = 0; k < sirc_pkg::DIV_STEP; k++) begin
      trial = {rem_w, quo_w[DIV_BITS-1]};
      ge    = (trial >= radix);
      rem_w = ge ? DW'(trial - radix) : trial[DW-1:0];
      quo_w = {quo_w[DIV_BITS-2:0], ge};
    end
  end

  assign step_last   = (step_cnt == STEP_W'(DIV_STEPS - 1));
  assign full        = (wr_idx == IDX_W'(VALUE_BITS - 1));
  assign digit_final = step_last && ((quo_w == '0) || full);

  // divider and digit pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
      wr_idx   <= '0;
      rd_ptr   <= '0;
    end else if (cmd.load) begin
      step_cnt <= '0;
      wr_idx   <= '0;
    end else if (cmd.div_step) begin
      if (step_last) begin
        step_cnt <= '0;
        if (digit_final) begin
          rd_ptr <= wr_idx;
        end else begin
          wr_idx <= wr_idx + 1'b1;
        end
      end else begin
        step_cnt <= step_cnt + 1'b1;
      end
    end else if (cmd.push_digit && rd_ptr != '0) begin
      rd_ptr <= rd_ptr - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo <= DIV_BITS'(mag);
      rem <= '0;
      neg <= value[VALUE_BITS-1];
    end else if (cmd.div_step) begin
      quo <= quo_w;
      rem <= step_last ? '0 : rem_w;
    end
  end

  // digit store, least significant digit first
  always_ff @(posedge clk) begin
    if (cmd.div_step && step_last) begin
      mem[wr_idx] <= rem_w;
    end
    if (cmd.rd) begin
      rd_data <= mem[rd_ptr];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push_sign || cmd.push_digit) begin
      out_valid <= 1'b1;
    end else if (chars.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_sign) begin
      character <= sirc_pkg::MINUS_CHAR;
      last      <= 1'b0;
    end else if (cmd.push_digit) begin
      character <= symbols[rd_data];
      last      <= (rd_ptr == '0);
    end
  end

  assign chars.valid     = out_valid;
  assign chars.character = character;
  assign chars.last      = last;

  assign status.alph_valid  = alph_valid;
  assign status.neg         = neg;
  assign status.digit_final = digit_final;
  assign status.ptr_zero    = (rd_ptr == '0);
  assign status.out_free    = !out_valid || chars.ready;

endmodule

// ----- design/signed_int_to_custom_radix_digits_top.sv -----
// Channel   Role    Handshake       Payload
// cfg       sink    valid / ready   index[1:0], data[63:0]
// numbers   sink    valid / ready   value[VALUE_BITS-1:0], signed
// chars     source  valid / ready   character[7:0], last
//
// The divider retires 8 quotient bits a cycle, each digit takes a digit store read
// plus a push into the output register, and the sign takes one push.
// Reset (rst, synchronous) clears the configuration registers, the control state, the pointers and the
// output valid, leaving the alphabet invalid. A stalled output holds its character; the next number is taken
// once the last character sits in the output register. An invalid alphabet drops the number.
module signed_int_to_custom_radix_digits_top #(
  parameter int VALUE_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  sirc_cfg_if.sink      cfg,
  sirc_value_if.sink    numbers,
  sirc_char_if.source   chars
);

  logic [sirc_pkg::COUNT_BITS-1:0] radix;
  sirc_pkg::sym_array_t            symbols;
  logic                            alph_valid;
  logic                            in_ready;
  sirc_pkg::dp_cmd_t               cmd;
  sirc_pkg::dp_status_t            status;

  assign numbers.ready = in_ready;

  sirc_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .radix      (radix),
    .symbols    (symbols),
    .alph_valid (alph_valid)
  );

  sirc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (numbers.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sirc_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .value      (numbers.value),
    .radix      (radix),
    .symbols    (symbols),
    .alph_valid (alph_valid),
    .cmd        (cmd),
    .status     (status),
    .chars      (chars)
  );

endmodule

// ----- design/sirc_checker.sv -----
module sirc_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [sirc_pkg::SYMBOL_BITS-1:0] character,
  input logic                             last
);

  // a waiting character stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped while stalled");

  // a waiting character keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(character) && $stable(last))
    else $error("output payload changed while stalled");

  // one number at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted item");

  // more characters pending means the input stays closed
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input ready while a number is still being emitted");

  // the sign always precedes a digit
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && character == sirc_pkg::MINUS_CHAR |-> !last)
    else $error("minus sign flagged as last character");

endmodule

bind signed_int_to_custom_radix_digits_top sirc_checker u_sirc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (numbers.valid),
  .in_ready  (numbers.ready),
  .out_valid (chars.valid),
  .out_ready (chars.ready),
  .character (chars.character),
  .last      (chars.last)
);
